@@ rtl/uwo_pkg.sv @@
// ============================================================================
// uwo_pkg: shared types and constants for the unison wavetable oscillator
// Sizes of the oscillator bank and wave table, field widths, item kinds,
// register indexes, controller states and the controller/datapath bundles.
// ============================================================================
package uwo_pkg;

    // Bank and table geometry
    localparam int MAX_PAIRS   = 8;
    localparam int TABLE_BITS  = 10;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int LEVELS      = 8;
    localparam int OSC_COUNT   = 1 + 2 * MAX_PAIRS;
    localparam int OSC_W       = $clog2(OSC_COUNT);
    localparam int SLOT_COUNT  = 2 * OSC_COUNT;
    localparam int SLOT_W      = OSC_W + 1;
    localparam int PAIR_W      = $clog2(MAX_PAIRS + 1);
    localparam int TABLE_WORDS = LEVELS * TABLE_SIZE;
    localparam int TAB_AW      = $clog2(TABLE_WORDS);

    // Field widths
    localparam int KIND_W     = 2;
    localparam int OSC_IDX_W  = 5;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 13;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int LEVEL_W    = 3;
    localparam int PAIRCNT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int FRAC_W    = 16;
    localparam int GAIN2_W   = 2 * GAIN_W;
    localparam int PROD_W    = 2 * (SAMPLE_W + 1);
    localparam int TERM_W    = SAMPLE_W + GAIN2_W + 1;
    localparam int SUM_W     = TERM_W + $clog2(OSC_COUNT);
    localparam int OUT_SHIFT = 24;

    localparam logic signed [SUM_W-1:0] SUM_OUT_MAX = SUM_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_OUT_MIN = SUM_W'(-(2 ** (OUT_W - 1)));
    localparam logic [OUT_W-1:0] OUT_MAX_CODE = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN_CODE = {1'b1, {(OUT_W - 1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 2'd0,
        KIND_SET_INC   = 2'd1,
        KIND_TABLE     = 2'd2,
        KIND_SET_PHASE = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAIR_COUNT    = 3'd0,
        REG_VELOCITY_GAIN = 3'd1,
        REG_UNISON_GAIN   = 3'd2,
        REG_TABLE_LEVEL   = 3'd3,
        REG_MUTE          = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    typedef struct packed {
        logic             load_item;
        logic             start;
        logic             issue;
        logic [OSC_W-1:0] osc;
        logic             ch;
        logic             out_load;
    } uwo_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } uwo_status_t;

endpackage

@@ rtl/uwo_channels.sv @@
// ============================================================================
// uwo_channels: valid/ready channels of the unison wavetable oscillator
// uwo_item_if carries input items, uwo_result_if carries stereo results.
// ============================================================================
interface uwo_item_if import uwo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [OSC_IDX_W-1:0]       osc_index;
    logic                       channel;
    logic [WORD_W-1:0]          word;
    logic [ADDR_W-1:0]          table_address;
    logic signed [SAMPLE_W-1:0] table_value;

    modport source (output valid, kind, osc_index, channel, word, table_address,
                    table_value, input ready);
    modport sink   (input valid, kind, osc_index, channel, word, table_address,
                    table_value, output ready);
endinterface

interface uwo_result_if import uwo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_sample;
    logic signed [OUT_W-1:0] right_sample;
    logic                    clipped;

    modport source (output valid, left_sample, right_sample, clipped, input ready);
    modport sink   (input valid, left_sample, right_sample, clipped, output ready);
endinterface

@@ rtl/uwo_ctrl.sv @@
// ============================================================================
// uwo_ctrl: sequencer of the unison wavetable oscillator
// Accepts items, walks the active oscillators of both channels through the
// datapath one per cycle, waits for the pipeline to drain, loads the result.
// ============================================================================
module uwo_ctrl import uwo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [KIND_W-1:0]    in_kind,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  logic [PAIRCNT_W-1:0] cfg_pairs,
    input  logic                 cfg_unison_zero,
    input  logic                 cfg_silent,
    input  uwo_status_t          status,
    output uwo_cmd_t             cmd
);

    state_t              state_reg, state_next;
    logic [OSC_W-1:0]    osc_reg, osc_next;
    logic                ch_reg, ch_next;
    logic [PAIR_W-1:0]   pairs_reg, pairs_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;
    logic [OSC_W-1:0]    osc_succ;
    logic                list_end;
    logic [OSC_W-1:0]    upper_top;
    logic [OSC_W-1:0]    pairs_osc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign upper_top = OSC_W'(MAX_PAIRS);
    assign pairs_osc = OSC_W'(pairs_reg);

    // Visit order: fundamental, upper voices 1..pairs, lower voices
    always_comb
    begin
        osc_succ = osc_reg + OSC_W'(1);
        list_end = 1'b0;
        if (osc_reg == '0)
        begin
            list_end = (pairs_reg == '0);
        end
        else if (osc_reg <= upper_top)
        begin
            if (osc_reg >= pairs_osc)
            begin
                osc_succ = upper_top + OSC_W'(1);
            end
        end
        else
        begin
            list_end = ((osc_reg - upper_top) >= pairs_osc);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        osc_next   = osc_reg;
        ch_next    = ch_reg;
        pairs_next = pairs_reg;
        cmd        = '0;
        cmd.osc    = osc_reg;
        cmd.ch     = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(in_kind) == KIND_TICK)
                    begin
                        cmd.start = 1'b1;
                        osc_next  = '0;
                        ch_next   = 1'b0;
                        if (cfg_unison_zero)
                        begin
                            pairs_next = '0;
                        end
                        else if (32'(cfg_pairs) > 32'(MAX_PAIRS))
                        begin
                            pairs_next = PAIR_W'(MAX_PAIRS);
                        end
                        else
                        begin
                            pairs_next = PAIR_W'(cfg_pairs);
                        end
                        state_next = cfg_silent ? ST_FINAL : ST_ISSUE;
                    end
                    else
                    begin
                        cmd.load_item = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (!list_end)
                begin
                    osc_next = osc_succ;
                end
                else if (!ch_reg)
                begin
                    osc_next = '0;
                    ch_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            osc_reg       <= '0;
            ch_reg        <= 1'b0;
            pairs_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            osc_reg       <= osc_next;
            ch_reg        <= ch_next;
            pairs_reg     <= pairs_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/uwo_dp.sv @@
// ============================================================================
// uwo_dp: datapath of the unison wavetable oscillator
// Phase, increment and wave table memories, a five-stage lookup pipeline
// (phase read, table read, interpolate, scale, accumulate) and saturation.
// ============================================================================
module uwo_dp import uwo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  uwo_cmd_t                   cmd,
    output uwo_status_t                status,
    input  logic [KIND_W-1:0]          in_kind,
    input  logic [OSC_IDX_W-1:0]       in_osc_index,
    input  logic                       in_channel,
    input  logic [WORD_W-1:0]          in_word,
    input  logic [ADDR_W-1:0]          in_table_address,
    input  logic signed [SAMPLE_W-1:0] in_table_value,
    input  logic [GAIN_W-1:0]          cfg_velocity,
    input  logic [GAIN_W-1:0]          cfg_unison,
    input  logic [LEVEL_W-1:0]         cfg_level,
    output logic signed [OUT_W-1:0]    left_sample,
    output logic signed [OUT_W-1:0]    right_sample,
    output logic                       clipped
);

    // Storage
    logic [WORD_W-1:0]          phase_mem [SLOT_COUNT];
    logic [WORD_W-1:0]          inc_mem   [OSC_COUNT];
    logic signed [SAMPLE_W-1:0] tab_mem   [TABLE_WORDS];
    logic [SLOT_COUNT-1:0]      phase_vld_reg;
    logic [OSC_COUNT-1:0]       inc_vld_reg;

    // Item decode
    logic             osc_ok, addr_ok;
    logic             inc_we, tab_we, set_phase;
    logic [OSC_W-1:0] load_osc;

    // Stage 1: phase and increment read data
    logic                  s1_valid_reg;
    logic                  s1_fund_reg;
    logic                  s1_ch_reg;
    logic [SLOT_W-1:0]     s1_slot_reg;
    logic [WORD_W-1:0]     phase_rd_reg, inc_rd_reg;
    logic                  phase_vld_rd_reg, inc_vld_rd_reg;
    logic [WORD_W-1:0]     phase_q, inc_q, phase_adv;
    logic [TABLE_BITS-1:0] idx_a, idx_b;
    logic [TAB_AW-1:0]     tab_ra, tab_rb, level_base;

    // Stage 2: table words
    logic                       s2_valid_reg, s2_fund_reg, s2_ch_reg;
    logic [FRAC_W-1:0]          s2_frac_reg;
    logic signed [SAMPLE_W-1:0] tab_a_reg, tab_b_reg;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;

    // Stage 3: interpolation product
    logic                       s3_valid_reg, s3_fund_reg, s3_ch_reg;
    logic signed [SAMPLE_W-1:0] s3_a_reg;
    logic signed [PROD_W-1:0]   s3_prod_reg;
    logic signed [PROD_W-1:0]   prod_sh;
    logic [SAMPLE_W:0]          interp;
    logic signed [SAMPLE_W-1:0] voice_val;
    logic [GAIN2_W-1:0]         gain_sel;
    logic signed [TERM_W-1:0]   term;

    // Stage 4: scaled term, accumulators
    logic                     s4_valid_reg, s4_ch_reg;
    logic signed [TERM_W-1:0] s4_term_reg;
    logic signed [SUM_W-1:0]  term_ext;
    logic signed [SUM_W-1:0]  sum_l_reg, sum_r_reg;
    logic [GAIN2_W-1:0]       gu_reg;

    // Output
    logic signed [OUT_W-1:0] left_reg, right_reg;
    logic                    clip_reg;
    logic signed [SUM_W-1:0] q_l, q_r;
    logic                    hi_l, lo_l, hi_r, lo_r;
    logic [OUT_W-1:0]        sat_l, sat_r;

    // Write port decode
    assign osc_ok    = 32'(in_osc_index) < 32'(OSC_COUNT);
    assign addr_ok   = 32'(in_table_address) < 32'(TABLE_WORDS);
    assign load_osc  = OSC_W'(in_osc_index);
    assign inc_we    = cmd.load_item && (kind_t'(in_kind) == KIND_SET_INC) && osc_ok;
    assign tab_we    = cmd.load_item && (kind_t'(in_kind) == KIND_TABLE) && addr_ok;
    assign set_phase = cmd.load_item && (kind_t'(in_kind) == KIND_SET_PHASE) && osc_ok;

    // Stage 1 lookup address and phase advance
    assign phase_q    = phase_vld_rd_reg ? phase_rd_reg : '0;
    assign inc_q      = inc_vld_rd_reg ? inc_rd_reg : '0;
    assign phase_adv  = phase_q + inc_q;
    assign idx_a      = phase_q[WORD_W-1 -: TABLE_BITS];
    assign idx_b      = idx_a + TABLE_BITS'(1);
    assign level_base = TAB_AW'(cfg_level) << TABLE_BITS;
    assign tab_ra     = level_base | TAB_AW'(idx_a);
    assign tab_rb     = level_base | TAB_AW'(idx_b);

    // Stage 2 slope times fraction
    assign diff = {tab_b_reg[SAMPLE_W-1], tab_b_reg} - {tab_a_reg[SAMPLE_W-1], tab_a_reg};
    assign prod = diff * $signed({1'b0, s2_frac_reg});

    // Stage 3 interpolated value times gain
    assign prod_sh   = s3_prod_reg >>> FRAC_W;
    assign interp    = {s3_a_reg[SAMPLE_W-1], s3_a_reg} + prod_sh[SAMPLE_W:0];
    assign voice_val = interp[SAMPLE_W-1:0];
    assign gain_sel  = s3_fund_reg ? {cfg_velocity, {FRAC_W{1'b0}}} : gu_reg;
    assign term      = voice_val * $signed({1'b0, gain_sel});

    assign term_ext = {{(SUM_W - TERM_W){s4_term_reg[TERM_W-1]}}, s4_term_reg};

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    // Memories
    always_ff @(posedge clk)
    begin
        if (set_phase)
        begin
            phase_mem[{load_osc, in_channel}] <= in_word;
        end
        else if (s1_valid_reg)
        begin
            phase_mem[s1_slot_reg] <= phase_adv;
        end
        if (inc_we)
        begin
            inc_mem[load_osc] <= in_word;
        end
        if (tab_we)
        begin
            tab_mem[in_table_address[TAB_AW-1:0]] <= in_table_value;
        end
        phase_rd_reg <= phase_mem[{cmd.osc, cmd.ch}];
        inc_rd_reg   <= inc_mem[cmd.osc];
        tab_a_reg    <= tab_mem[tab_ra];
        tab_b_reg    <= tab_mem[tab_rb];
    end

    // Valid bits and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg    <= '0;
            inc_vld_reg      <= '0;
            phase_vld_rd_reg <= 1'b0;
            inc_vld_rd_reg   <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
        end
        else
        begin
            if (set_phase)
            begin
                phase_vld_reg[{load_osc, in_channel}] <= 1'b1;
            end
            else if (s1_valid_reg)
            begin
                phase_vld_reg[s1_slot_reg] <= 1'b1;
            end
            if (inc_we)
            begin
                inc_vld_reg[load_osc] <= 1'b1;
            end
            phase_vld_rd_reg <= phase_vld_reg[{cmd.osc, cmd.ch}];
            inc_vld_rd_reg   <= inc_vld_reg[cmd.osc];
            s1_valid_reg     <= cmd.issue;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
        end
    end

    // Pipeline payload and accumulators
    always_ff @(posedge clk)
    begin
        s1_fund_reg <= (cmd.osc == '0);
        s1_ch_reg   <= cmd.ch;
        s1_slot_reg <= {cmd.osc, cmd.ch};

        s2_fund_reg <= s1_fund_reg;
        s2_ch_reg   <= s1_ch_reg;
        s2_frac_reg <= phase_q[WORD_W-1-TABLE_BITS -: FRAC_W];

        s3_fund_reg <= s2_fund_reg;
        s3_ch_reg   <= s2_ch_reg;
        s3_a_reg    <= tab_a_reg;
        s3_prod_reg <= prod;

        s4_ch_reg   <= s3_ch_reg;
        s4_term_reg <= term;

        if (cmd.start)
        begin
            sum_l_reg <= '0;
            sum_r_reg <= '0;
            gu_reg    <= cfg_velocity * cfg_unison;
        end
        else if (s4_valid_reg)
        begin
            if (s4_ch_reg)
            begin
                sum_r_reg <= sum_r_reg + term_ext;
            end
            else
            begin
                sum_l_reg <= sum_l_reg + term_ext;
            end
        end
    end

    // Saturation to the output width
    assign q_l   = sum_l_reg >>> OUT_SHIFT;
    assign q_r   = sum_r_reg >>> OUT_SHIFT;
    assign hi_l  = q_l > SUM_OUT_MAX;
    assign lo_l  = q_l < SUM_OUT_MIN;
    assign hi_r  = q_r > SUM_OUT_MAX;
    assign lo_r  = q_r < SUM_OUT_MIN;
    assign sat_l = hi_l ? OUT_MAX_CODE : (lo_l ? OUT_MIN_CODE : q_l[OUT_W-1:0]);
    assign sat_r = hi_r ? OUT_MAX_CODE : (lo_r ? OUT_MIN_CODE : q_r[OUT_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_reg  <= sat_l;
            right_reg <= sat_r;
            clip_reg  <= hi_l || lo_l || hi_r || lo_r;
        end
    end

    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign clipped      = clip_reg;

endmodule

@@ rtl/unison_wavetable_oscillator.sv @@
// ============================================================================
// unison_wavetable_oscillator: stereo wavetable oscillator bank with unison
// A fundamental plus up to eight detuned upper/lower pairs, each with a left
// and a right phase. A tick sums the interpolated table values of all active
// oscillators per channel, scaled by velocity and unison gain, saturates to
// 24 bits and advances the phases. Other items load increments, phases and
// table words.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+----------------------------------
//   item_ch   | in  | valid/ready        | kind, osc_index, channel, word,
//             |     |                    | table_address, table_value
//   result_ch | out | valid/ready        | left_sample, right_sample, clipped
//   cfg       | in  | cfg_we, no stall   | cfg_index, cfg_data
//
// Load items (set increment, set phase, table write) are written from the
// input and leave it ready. A tick looks up N = 1 + 2*pairs oscillators
// per channel (no pairs at zero unison gain); a silent tick skips them.
// The lookup pipeline handles one oscillator-channel per cycle; the wave
// table read port pair and the single scaling multiplier set that figure.
// Reset clears control state and phase/inc valid bits; no clearing pass.
// A held result stalls the next tick's final load and input, not lookups.
// ============================================================================
module unison_wavetable_oscillator import uwo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    uwo_item_if.sink              item_ch,
    uwo_result_if.source          result_ch
);

    // Configuration registers
    logic [PAIRCNT_W-1:0] pair_count_reg;
    logic [GAIN_W-1:0]    velocity_gain_reg;
    logic [GAIN_W-1:0]    unison_gain_reg;
    logic [LEVEL_W-1:0]   table_level_reg;
    logic                 mute_reg;

    logic        silent;
    logic        unison_zero;
    uwo_cmd_t    cmd;
    uwo_status_t status;

    // Write one register per enabled cycle; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg    <= '0;
            velocity_gain_reg <= '0;
            unison_gain_reg   <= '0;
            table_level_reg   <= '0;
            mute_reg          <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAIR_COUNT:    pair_count_reg    <= cfg_data[PAIRCNT_W-1:0];
                REG_VELOCITY_GAIN: velocity_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_UNISON_GAIN:   unison_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_TABLE_LEVEL:   table_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_MUTE:          mute_reg          <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Silence the tick when muted, at zero velocity or with no usable level
    assign silent = mute_reg || (velocity_gain_reg == '0)
                    || (32'(table_level_reg) >= 32'(LEVELS));
    assign unison_zero = (unison_gain_reg == '0);

    // Sequencer: accept items, issue oscillator lookups, hand over results
    uwo_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (item_ch.valid),
        .in_kind         (item_ch.kind),
        .in_ready        (item_ch.ready),
        .out_ready       (result_ch.ready),
        .out_valid       (result_ch.valid),
        .cfg_pairs       (pair_count_reg),
        .cfg_unison_zero (unison_zero),
        .cfg_silent      (silent),
        .status          (status),
        .cmd             (cmd)
    );

    // Memories, lookup pipeline, accumulators and the output register
    uwo_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_kind          (item_ch.kind),
        .in_osc_index     (item_ch.osc_index),
        .in_channel       (item_ch.channel),
        .in_word          (item_ch.word),
        .in_table_address (item_ch.table_address),
        .in_table_value   (item_ch.table_value),
        .cfg_velocity     (velocity_gain_reg),
        .cfg_unison       (unison_gain_reg),
        .cfg_level        (table_level_reg),
        .left_sample      (result_ch.left_sample),
        .right_sample     (result_ch.right_sample),
        .clipped          (result_ch.clipped)
    );

endmodule

@@ rtl/uwo_checker.sv @@
// ============================================================================
// uwo_checker: port-level checks for the unison wavetable oscillator
// Watches item and result transactions and the saturation flag.
// ============================================================================
module uwo_checker import uwo_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [KIND_W-1:0]       in_kind,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] left_sample,
    input logic signed [OUT_W-1:0] right_sample,
    input logic                    clipped
);

    logic tick_in, load_in;

    assign tick_in = in_valid && in_ready && (kind_t'(in_kind) == KIND_TICK);
    assign load_in = in_valid && in_ready && (kind_t'(in_kind) != KIND_TICK);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        load_in |=> in_ready)
        else $error("load transaction did not free the input");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_in |=> !in_ready)
        else $error("input ready right after a tick");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (left_sample == OUT_MAX_CODE) || (left_sample == OUT_MIN_CODE) ||
            (right_sample == OUT_MAX_CODE) || (right_sample == OUT_MIN_CODE))
        else $error("clipped set with no sample at a rail");

endmodule

bind unison_wavetable_oscillator uwo_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item_ch.valid),
    .in_ready     (item_ch.ready),
    .in_kind      (item_ch.kind),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .left_sample  (result_ch.left_sample),
    .right_sample (result_ch.right_sample),
    .clipped      (result_ch.clipped)
);
